// ===== rtl/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

    localparam int CH_W = 8;
    localparam int OUT_W = 15;
    localparam int HUE_FRAC_BITS = 6;

    localparam int HUE_SCALE = 60 << HUE_FRAC_BITS;
    localparam int HUE_LIMIT = 360 << HUE_FRAC_BITS;
    localparam int PCT_SCALE = 25600;
    localparam int PCT_UNIT = 100;
    localparam int CH_MAX = (1 << CH_W) - 1;

    localparam int HUE_NUM_W = $clog2(HUE_SCALE * CH_MAX + 1);
    localparam int PCT_NUM_W = $clog2(PCT_SCALE * CH_MAX + 1);
    localparam int NUM_MAX_W = (HUE_NUM_W > PCT_NUM_W) ? HUE_NUM_W : PCT_NUM_W;

    // long division, a few quotient bits per pipeline stage
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGES = (NUM_MAX_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_NUM_W = DIV_STAGES * DIV_STEPS;
    localparam int NUM_STAGES = DIV_STAGES + 2;

    localparam logic [DIV_NUM_W-1:0] HUE_OFS_0 = '0;
    localparam logic [DIV_NUM_W-1:0] HUE_OFS_120 = DIV_NUM_W'(120 << HUE_FRAC_BITS);
    localparam logic [DIV_NUM_W-1:0] HUE_OFS_240 = DIV_NUM_W'(240 << HUE_FRAC_BITS);
    localparam logic [DIV_NUM_W-1:0] HUE_OFS_360 = DIV_NUM_W'(360 << HUE_FRAC_BITS);

    typedef struct packed {
        logic                 gray;
        logic                 neg;
        logic [DIV_NUM_W-1:0] base;
        logic [OUT_W-1:0]     pct_max;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [DIV_NUM_W-1:0] hue_num;
        logic [CH_W-1:0]      delta;
        logic [DIV_NUM_W-1:0] sat_num;
        logic [CH_W-1:0]      max_ch;
    } front_t;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] quo;
        logic                 rem_nz;
    } div_res_t;

endpackage

// ===== rtl/rgbhsv_front.sv =====
module rgbhsv_front (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rgbhsv_pkg::CH_W-1:0] red,
    input  logic [rgbhsv_pkg::CH_W-1:0] green,
    input  logic [rgbhsv_pkg::CH_W-1:0] blue,
    output rgbhsv_pkg::front_t        front
);
    import rgbhsv_pkg::*;

    logic [CH_W-1:0] max_ch;
    logic [CH_W-1:0] min_ch;
    logic [CH_W-1:0] delta;
    logic [CH_W-1:0] diff;
    front_t          front_reg;
    front_t          front_next;

    always_comb
    begin
        max_ch = red;
        if (green > max_ch)
            max_ch = green;
        if (blue > max_ch)
            max_ch = blue;
        min_ch = red;
        if (green < min_ch)
            min_ch = green;
        if (blue < min_ch)
            min_ch = blue;
        delta = max_ch - min_ch;

        front_next.side.gray = (delta == '0);
        if (max_ch == red)
        begin
            if (green >= blue)
            begin
                front_next.side.base = HUE_OFS_0;
                front_next.side.neg = 1'b0;
                diff = green - blue;
            end
            else
            begin
                front_next.side.base = HUE_OFS_360;
                front_next.side.neg = 1'b1;
                diff = blue - green;
            end
        end
        else if (max_ch == green)
        begin
            front_next.side.base = HUE_OFS_120;
            if (blue >= red)
            begin
                front_next.side.neg = 1'b0;
                diff = blue - red;
            end
            else
            begin
                front_next.side.neg = 1'b1;
                diff = red - blue;
            end
        end
        else
        begin
            front_next.side.base = HUE_OFS_240;
            if (red >= green)
            begin
                front_next.side.neg = 1'b0;
                diff = red - green;
            end
            else
            begin
                front_next.side.neg = 1'b1;
                diff = green - red;
            end
        end
        front_next.side.pct_max = OUT_W'(PCT_UNIT) * OUT_W'(max_ch);

        front_next.hue_num = DIV_NUM_W'(HUE_SCALE) * DIV_NUM_W'(diff);
        front_next.delta = delta;
        front_next.sat_num = DIV_NUM_W'(PCT_SCALE) * DIV_NUM_W'(delta);
        front_next.max_ch = max_ch;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    assign front = front_reg;

endmodule

// ===== rtl/rgbhsv_div.sv =====
module rgbhsv_div (
    input  logic                                 clk,
    input  logic [rgbhsv_pkg::DIV_STAGES-1:0]    en,
    input  logic [rgbhsv_pkg::DIV_NUM_W-1:0]     num,
    input  logic [rgbhsv_pkg::CH_W-1:0]          den,
    output rgbhsv_pkg::div_res_t                 res
);
    import rgbhsv_pkg::*;

    logic [CH_W-1:0]      rem_in   [DIV_STAGES];
    logic [DIV_NUM_W-1:0] num_in   [DIV_STAGES];
    logic [CH_W-1:0]      den_in   [DIV_STAGES];
    logic [CH_W-1:0]      rem_next [DIV_STAGES];
    logic [DIV_NUM_W-1:0] num_next [DIV_STAGES];
    logic [CH_W-1:0]      rem_reg  [DIV_STAGES];
    logic [DIV_NUM_W-1:0] num_reg  [DIV_STAGES];
    logic [CH_W-1:0]      den_reg  [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_stage
            if (g == 0)
            begin : g_first
                assign rem_in[g] = '0;
                assign num_in[g] = num;
                assign den_in[g] = den;
            end
            else
            begin : g_rest
                assign rem_in[g] = rem_reg[g-1];
                assign num_in[g] = num_reg[g-1];
                assign den_in[g] = den_reg[g-1];
            end

            // restoring steps, one quotient bit shifted in per step
            always_comb
            begin
                logic [CH_W:0]        trial;
                logic [CH_W-1:0]      rem_t;
                logic [DIV_NUM_W-1:0] num_t;
                logic                 qbit;
                rem_t = rem_in[g];
                num_t = num_in[g];
                for (int i = 0; i < DIV_STEPS; i++)
                begin
                    trial = {rem_t, num_t[DIV_NUM_W-1]};
                    if (trial >= {1'b0, den_in[g]})
                    begin
                        rem_t = CH_W'(trial - {1'b0, den_in[g]});
                        qbit = 1'b1;
                    end
                    else
                    begin
                        rem_t = trial[CH_W-1:0];
                        qbit = 1'b0;
                    end
                    num_t = {num_t[DIV_NUM_W-2:0], qbit};
                end
                rem_next[g] = rem_t;
                num_next[g] = num_t;
            end

            always_ff @(posedge clk)
            begin
                if (en[g])
                begin
                    rem_reg[g] <= rem_next[g];
                    num_reg[g] <= num_next[g];
                    den_reg[g] <= den_in[g];
                end
            end
        end
    endgenerate

    assign res.quo = num_reg[DIV_STAGES-1];
    assign res.rem_nz = |rem_reg[DIV_STAGES-1];

endmodule

// ===== rtl/rgbhsv_back.sv =====
module rgbhsv_back (
    input  logic                           clk,
    input  logic                           en,
    input  rgbhsv_pkg::side_t              side,
    input  rgbhsv_pkg::div_res_t           hue_res,
    input  rgbhsv_pkg::div_res_t           sat_res,
    output logic [rgbhsv_pkg::OUT_W-1:0]   hue,
    output logic [rgbhsv_pkg::OUT_W-1:0]   saturation,
    output logic [rgbhsv_pkg::OUT_W-1:0]   brightness
);
    import rgbhsv_pkg::*;

    logic [DIV_NUM_W-1:0] hue_full;
    logic [OUT_W-1:0]     hue_reg;
    logic [OUT_W-1:0]     sat_reg;
    logic [OUT_W-1:0]     val_reg;
    logic [OUT_W-1:0]     hue_next;
    logic [OUT_W-1:0]     sat_next;
    logic [OUT_W-1:0]     val_next;

    always_comb
    begin
        // negative offsets round the quotient up so the sum stays a floor
        if (side.neg)
            hue_full = side.base - hue_res.quo - DIV_NUM_W'(hue_res.rem_nz);
        else
            hue_full = side.base + hue_res.quo;
        if (side.gray)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = hue_full[OUT_W-1:0];
            sat_next = sat_res.quo[OUT_W-1:0];
        end
        // 256 * x / 255 as x + x / 255
        val_next = side.pct_max
                 + ((side.pct_max + OUT_W'(1) + (side.pct_max >> CH_W)) >> CH_W);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign hue = hue_reg;
    assign saturation = sat_reg;
    assign brightness = val_reg;

endmodule

// ===== rtl/rgb_to_hsv.sv =====
// rgb to hsv pixel converter
// pixel request: red, green, blue, taken when pix_valid and pix_ready are high
// hsv request: hue (degrees * 64), saturation and brightness (percent * 256),
//   offered with hsv_valid, taken when hsv_ready is high
// throughput: one pixel per clock while hsv_ready stays high
// path: hsv_valid rises once the pixel has passed the front stage, the long
//   division pipeline (4 quotient bits per stage, 6 stages) and the output
//   register
// each stage holds its own valid bit; an empty stage always loads, so bubbles
//   close up while the receiver stalls
// stall: when hsv_ready is low and every stage holds a pixel, pix_ready drops;
//   held pixels stay in place, none is dropped or repeated
// reset: all valid bits clear, hsv_valid goes low and pix_ready comes up high
module rgb_to_hsv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    output logic                           pix_ready,
    input  logic [rgbhsv_pkg::CH_W-1:0]    red,
    input  logic [rgbhsv_pkg::CH_W-1:0]    green,
    input  logic [rgbhsv_pkg::CH_W-1:0]    blue,
    output logic                           hsv_valid,
    input  logic                           hsv_ready,
    output logic [rgbhsv_pkg::OUT_W-1:0]   hue,
    output logic [rgbhsv_pkg::OUT_W-1:0]   saturation,
    output logic [rgbhsv_pkg::OUT_W-1:0]   brightness
);
    import rgbhsv_pkg::*;

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] stage_en;
    front_t                front;
    side_t                 side_reg [DIV_STAGES];
    div_res_t              hue_res;
    div_res_t              sat_res;

    always_comb
    begin
        stage_en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || hsv_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            stage_en[k] = !v_reg[k] || stage_en[k+1];
        v_next = v_reg;
        if (stage_en[0])
            v_next[0] = pix_valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (stage_en[k])
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign pix_ready = stage_en[0];
    assign hsv_valid = v_reg[NUM_STAGES-1];

    rgbhsv_front u_front (
        .clk   (clk),
        .en    (stage_en[0]),
        .red   (red),
        .green (green),
        .blue  (blue),
        .front (front)
    );

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (stage_en[g+1])
                begin
                    if (g == 0)
                        side_reg[g] <= front.side;
                    else
                        side_reg[g] <= side_reg[(g == 0) ? 0 : g - 1];
                end
            end
        end
    endgenerate

    rgbhsv_div u_div_hue (
        .clk (clk),
        .en  (stage_en[DIV_STAGES:1]),
        .num (front.hue_num),
        .den (front.delta),
        .res (hue_res)
    );

    rgbhsv_div u_div_sat (
        .clk (clk),
        .en  (stage_en[DIV_STAGES:1]),
        .num (front.sat_num),
        .den (front.max_ch),
        .res (sat_res)
    );

    rgbhsv_back u_back (
        .clk        (clk),
        .en         (stage_en[NUM_STAGES-1]),
        .side       (side_reg[DIV_STAGES-1]),
        .hue_res    (hue_res),
        .sat_res    (sat_res),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    // black pixel gives zero hue and saturation
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && (brightness == '0) |-> (hue == '0) && (saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (HUE_FRAC_BITS > 6) || (32'(hue) < HUE_LIMIT))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (32'(saturation) <= PCT_SCALE) && (32'(brightness) <= PCT_SCALE))
        else $error("percent output out of range");

    // backpressure reaches the input only with a full pipeline
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> (&v_reg) && !hsv_ready)
        else $error("input stalled with an empty stage");

endmodule
